// ===== src/nmk_pkg.sv =====
// ----------------------------------------------------------------------------
// Newmark stepper package
// Shared widths, register indexes and arithmetic-unit operations for the Newmark stepper.
// ----------------------------------------------------------------------------
package nmk_pkg;

    localparam int FRAC_BITS_DEF  = 24;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int CFG_WIDTH      = 32;
    localparam int CFG_IDX_WIDTH  = 3;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_OMEGA     = 3'd0,
        REG_ZETA      = 3'd1,
        REG_BETA      = 3'd2,
        REG_GAMMA     = 3'd3,
        REG_STEP      = 3'd4,
        REG_VFACTOR   = 3'd5,
        REG_INIT_DISP = 3'd6,
        REG_TOTAL     = 3'd7
    } cfg_idx_t;

    // Operations of the shared arithmetic unit.
    typedef enum logic [1:0] {
        OP_MUL = 2'd0,
        OP_ADD = 2'd1,
        OP_SUB = 2'd2,
        OP_DIV = 2'd3
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_ctrl_t;

endpackage

// ===== src/nmk_alu.sv =====
// ----------------------------------------------------------------------------
// Newmark shared arithmetic unit
// Saturating add, subtract, rounded fixed point multiply and restoring divide.
// ----------------------------------------------------------------------------
module nmk_alu
    import nmk_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  alu_ctrl_t                    ctrl,
    input  logic signed [DATA_WIDTH-1:0] a,
    input  logic signed [DATA_WIDTH-1:0] b,
    output logic signed [DATA_WIDTH-1:0] result,
    output logic                         done
);

    localparam int W   = DATA_WIDTH;
    localparam int PW  = 2 * W;
    localparam int NUM = W + FRAC_BITS;
    localparam int CW  = $clog2(NUM + 1);
    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    // Division state: the numerator magnitude is shifted through the remainder.
    logic [NUM-1:0]  num_reg, num_next;
    logic [W:0]      rem_reg, rem_next;
    logic [NUM-1:0]  quo_reg, quo_next;
    logic [W-1:0]    den_reg, den_next;
    logic            neg_reg, neg_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            zero_reg, zero_next;
    logic [W-1:0]    res_reg, res_next;
    logic            done_reg, done_next;

    logic [W-1:0]  ma, mb;
    logic [PW-1:0] prod;
    logic [PW-1:0] prod_r;
    logic [PW-FRAC_BITS:0] shifted;
    logic [W:0]    lim;
    logic          mneg;
    logic [W-1:0]  bneg;
    logic signed [W:0] sum;
    logic [W:0]    rem_sh;
    logic [W-1:0]  mag_out;
    logic [NUM-1:0] qlim;

    always_comb
    begin
        ma      = a[W-1] ? W'(-a) : a;
        mb      = b[W-1] ? W'(-b) : b;
        mneg    = a[W-1] ^ b[W-1];
        prod    = PW'(ma) * PW'(mb);
        prod_r  = prod + (PW'(1) << (FRAC_BITS - 1));
        shifted = (PW-FRAC_BITS+1)'(prod_r >> FRAC_BITS);
        if (prod_r < prod)
        begin
            shifted = {1'b1, shifted[PW-FRAC_BITS-1:0]};
        end
        lim = {1'b0, MAXV} + (W+1)'(mneg);
        // Subtraction adds the saturated negation, so the most negative
        // subtrahend counts as the largest positive value.
        bneg = (b == MINV) ? MAXV : W'(-b);
        sum = (ctrl.op == OP_SUB) ? ({a[W-1], a} + {bneg[W-1], bneg})
                                  : ({a[W-1], a} + {b[W-1], b});
        rem_sh  = {rem_reg[W-1:0], num_reg[NUM-1]};
        qlim    = NUM'({1'b0, MAXV}) + NUM'(neg_reg);
        mag_out = '0;
    end

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        zero_next = zero_reg;
        res_next  = res_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            case (ctrl.op)
                OP_MUL:
                begin
                    if ((W+1)'(shifted) > lim || (shifted >> (W + 1)) != 0)
                    begin
                        res_next = mneg ? MINV : MAXV;
                    end
                    else
                    begin
                        res_next = mneg ? W'(-shifted) : W'(shifted);
                    end
                    done_next = 1'b1;
                end
                OP_ADD, OP_SUB:
                begin
                    if (sum[W] != sum[W-1])
                    begin
                        res_next = sum[W] ? MINV : MAXV;
                    end
                    else
                    begin
                        res_next = sum[W-1:0];
                    end
                    done_next = 1'b1;
                end
                OP_DIV:
                begin
                    num_next  = {ma, {FRAC_BITS{1'b0}}};
                    neg_next  = a[W-1];
                    den_next  = b;
                    zero_next = b[W-1] || (b == '0);
                    rem_next  = '0;
                    quo_next  = '0;
                    cnt_next  = CW'(NUM);
                    busy_next = 1'b1;
                end
                default:
                begin
                    res_next = '0;
                end
            endcase
        end
        else if (busy_reg)
        begin
            // One restoring step per cycle.
            num_next = num_reg << 1;
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = rem_sh - {1'b0, den_reg};
                quo_next = {quo_reg[NUM-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[NUM-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (zero_reg)
                begin
                    res_next = '0;
                end
                else if (quo_next > qlim)
                begin
                    res_next = neg_reg ? MINV : MAXV;
                end
                else
                begin
                    res_next = neg_reg ? W'(-quo_next) : W'(quo_next);
                end
            end
        end
        res_next = res_next | mag_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
        res_reg  <= res_next;
    end

    assign result = res_reg;
    assign done   = done_reg;

endmodule

// ===== src/newmark_implicit_oscillator_step_core.sv =====
// ----------------------------------------------------------------------------
// Newmark implicit oscillator step core
// Steps a damped single degree of freedom oscillator with the Newmark scheme.
// ----------------------------------------------------------------------------
// A restart or a held advance goes through the output state to the output
// register; a full step first issues 45 shared-unit operations in turn, one of
// them the bit-serial divide, and then updates the state in the finish state.
// Throughput: one item at a time; in_stall is high while an item is in work.
// Reset clears the state and the output register and sets the configuration
// registers to their defaults.
module newmark_implicit_oscillator_step_core
    import nmk_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]     cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     restart,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [31:0]       displacement,
    output logic signed [31:0]       velocity,
    output logic [31:0]              step_number,
    output logic                     finished
);

    localparam int W = DATA_WIDTH;
    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
    localparam logic [64:0] ONE_WIDE  = 65'(1) << FRAC_BITS;
    localparam logic [64:0] HALF_WIDE = 65'(1) << (FRAC_BITS - 1);
    localparam logic [64:0] MAX_WIDE  = 65'({1'b0, MAXV});
    localparam logic [W-1:0] ONE_C  = (ONE_WIDE > MAX_WIDE) ? MAXV : ONE_WIDE[W-1:0];
    localparam logic [W-1:0] HALF_C = (HALF_WIDE > MAX_WIDE) ? MAXV : HALF_WIDE[W-1:0];

    // Scratch slots of the microcode.
    typedef enum logic [4:0] {
        S_W, S_Z, S_B, S_G, S_H, S_VF, S_D, S_V, S_ONE, S_HALF,
        S_W2, S_ZW, S_C, S_H2, S_HB, S_RG, S_T1, S_T2, S_AI, S_A0,
        S_A2, S_A3, S_NUM, S_AI1, S_V1, S_D1, S_T3
    } slot_t;

    typedef struct packed {
        alu_op_t op;
        slot_t   a;
        slot_t   b;
        slot_t   dst;
    } uop_t;

    localparam int NOPS = 37;

    function automatic uop_t ucode(input logic [5:0] pc);
        uop_t u;
        begin
            u = '{OP_ADD, S_W, S_W, S_W};
            case (pc)
                6'd0:  u = '{OP_MUL, S_W,   S_W,   S_W2};
                6'd1:  u = '{OP_MUL, S_Z,   S_W,   S_ZW};
                6'd2:  u = '{OP_ADD, S_ZW,  S_ZW,  S_C};
                6'd3:  u = '{OP_MUL, S_H,   S_H,   S_H2};
                6'd4:  u = '{OP_SUB, S_HALF, S_B,  S_HB};
                6'd5:  u = '{OP_SUB, S_ONE, S_G,   S_RG};
                6'd6:  u = '{OP_MUL, S_W2,  S_D,   S_T1};
                6'd7:  u = '{OP_MUL, S_C,   S_V,   S_T2};
                6'd8:  u = '{OP_SUB, S_ZW,  S_ZW,  S_T3};   // zero
                6'd9:  u = '{OP_SUB, S_T3,  S_T1,  S_AI};   // -(w2*d)
                6'd10: u = '{OP_SUB, S_AI,  S_T2,  S_AI};
                6'd11: u = '{OP_MUL, S_W2,  S_B,   S_T2};
                6'd12: u = '{OP_MUL, S_T2,  S_H2,  S_T2};
                6'd13: u = '{OP_ADD, S_ONE, S_T2,  S_A0};
                6'd14: u = '{OP_MUL, S_C,   S_G,   S_T2};
                6'd15: u = '{OP_MUL, S_T2,  S_H,   S_T2};
                6'd16: u = '{OP_ADD, S_A0,  S_T2,  S_A0};
                6'd17: u = '{OP_MUL, S_W2,  S_H,   S_T2};
                6'd18: u = '{OP_ADD, S_T2,  S_C,   S_A2};
                6'd19: u = '{OP_MUL, S_W2,  S_H2,  S_T2};
                6'd20: u = '{OP_MUL, S_T2,  S_HB,  S_A3};
                6'd21: u = '{OP_MUL, S_C,   S_H,   S_T2};
                6'd22: u = '{OP_MUL, S_T2,  S_RG,  S_T2};
                6'd23: u = '{OP_ADD, S_A3,  S_T2,  S_A3};
                6'd24: u = '{OP_MUL, S_A2,  S_V,   S_T2};
                6'd25: u = '{OP_ADD, S_T1,  S_T2,  S_NUM};
                6'd26: u = '{OP_MUL, S_A3,  S_AI,  S_T2};
                6'd27: u = '{OP_ADD, S_NUM, S_T2,  S_NUM};
                6'd28: u = '{OP_SUB, S_T3,  S_NUM, S_NUM};
                6'd29: u = '{OP_DIV, S_NUM, S_A0,  S_AI1};
                6'd30: u = '{OP_MUL, S_H,   S_RG,  S_T2};
                6'd31: u = '{OP_MUL, S_T2,  S_AI,  S_T2};
                6'd32: u = '{OP_ADD, S_V,   S_T2,  S_V1};
                6'd33: u = '{OP_MUL, S_H,   S_G,   S_T2};
                6'd34: u = '{OP_MUL, S_T2,  S_AI1, S_T2};
                6'd35: u = '{OP_ADD, S_V1,  S_T2,  S_V1};
                6'd36: u = '{OP_MUL, S_H,   S_V,   S_T2};
                default: u = '{OP_ADD, S_W, S_W, S_W};
            endcase
            return u;
        end
    endfunction

    // Tail of the microcode for the displacement update and the velocity scaling.
    function automatic uop_t ucode_tail(input logic [2:0] pc);
        uop_t u;
        begin
            case (pc)
                3'd0: u = '{OP_ADD, S_D,  S_T2,  S_D1};
                3'd1: u = '{OP_MUL, S_H2, S_HB,  S_T2};
                3'd2: u = '{OP_MUL, S_T2, S_AI,  S_T2};
                3'd3: u = '{OP_ADD, S_D1, S_T2,  S_D1};
                3'd4: u = '{OP_MUL, S_H2, S_B,   S_T2};
                3'd5: u = '{OP_MUL, S_T2, S_AI1, S_T2};
                3'd6: u = '{OP_ADD, S_D1, S_T2,  S_D1};
                default: u = '{OP_MUL, S_V1, S_VF, S_V1};
            endcase
            return u;
        end
    endfunction

    typedef enum logic [2:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_FINISH, ST_OUT} state_t;

    logic [30:0] omega_reg, zeta_reg, step_reg, total_reg;
    logic [24:0] beta_reg, gamma_reg, vf_reg;
    logic [31:0] init_reg;

    logic [W-1:0] disp_reg, vel_reg, elapsed_reg;
    logic [31:0]  count_reg;
    logic         done_reg;
    logic [W-1:0] scratch_reg [27];
    state_t       state_reg;
    logic [5:0]   pc_reg;
    logic         out_valid_reg;
    logic [31:0]  out_disp_reg, out_vel_reg, out_step_reg;
    logic         out_fin_reg;

    logic [W-1:0] h_c, tt_c;
    logic [W:0]   tsum;
    logic [W-1:0] tsum_sat;
    uop_t         uop;
    alu_ctrl_t    actrl;
    logic [W-1:0] alu_res;
    logic         alu_done;
    logic         accept;

    // An unsigned register clamped into the word range.
    function automatic logic [W-1:0] clamp_u(input logic [31:0] x);
        begin
            return ({32'd0, x} > 64'(MAXV)) ? MAXV : W'(x);
        end
    endfunction

    // A signed 32-bit register clamped into the word range.
    function automatic logic [W-1:0] clamp_s(input logic [31:0] x);
        logic signed [64:0] xs;
        logic signed [64:0] hi;
        logic signed [64:0] lo;
        begin
            xs = 65'(signed'(x));
            hi = MAX_WIDE;
            lo = -hi - 65'sd1;
            if (xs > hi)
            begin
                return MAXV;
            end
            if (xs < lo)
            begin
                return MINV;
            end
            return W'(xs);
        end
    endfunction

    function automatic logic [31:0] out_sat(input logic [W-1:0] x);
        logic signed [W-1:0] s;
        begin
            s = x;
            if (64'(signed'(s)) > 64'sd2147483647)
            begin
                return 32'h7fff_ffff;
            end
            if (64'(signed'(s)) < -64'sd2147483648)
            begin
                return 32'h8000_0000;
            end
            return 32'(s);
        end
    endfunction

    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign h_c  = clamp_u({1'b0, step_reg});
    assign tt_c = clamp_u({1'b0, total_reg});
    assign tsum = {1'b0, elapsed_reg} + {1'b0, h_c};
    assign tsum_sat = (tsum > {1'b0, MAXV}) ? MAXV : tsum[W-1:0];
    assign uop = (pc_reg < 6'(NOPS)) ? ucode(pc_reg) : ucode_tail(3'(pc_reg - 6'(NOPS)));
    assign actrl.start = (state_reg == ST_ISSUE);
    assign actrl.op    = uop.op;

    nmk_alu #(
        .FRAC_BITS  (FRAC_BITS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (actrl),
        .a      (scratch_reg[uop.a]),
        .b      (scratch_reg[uop.b]),
        .result (alu_res),
        .done   (alu_done)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            omega_reg <= 31'd16777216;
            zeta_reg  <= '0;
            beta_reg  <= 25'd4194304;
            gamma_reg <= 25'd8388608;
            step_reg  <= 31'd167772;
            vf_reg    <= 25'd16777216;
            init_reg  <= 32'd1677722;
            total_reg <= 31'd16777216;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_OMEGA:     omega_reg <= cfg_data[30:0];
                REG_ZETA:      zeta_reg  <= cfg_data[30:0];
                REG_BETA:      beta_reg  <= cfg_data[24:0];
                REG_GAMMA:     gamma_reg <= cfg_data[24:0];
                REG_STEP:      step_reg  <= cfg_data[30:0];
                REG_VFACTOR:   vf_reg    <= cfg_data[24:0];
                REG_INIT_DISP: init_reg  <= cfg_data;
                REG_TOTAL:     total_reg <= cfg_data[30:0];
                default:       omega_reg <= omega_reg;
            endcase
        end
    end

    // Sequencer, state and output register. The output register is loaded only
    // when empty or being taken, so a result waits until its transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            disp_reg      <= '0;
            vel_reg       <= '0;
            elapsed_reg   <= '0;
            count_reg     <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_disp_reg  <= '0;
            out_vel_reg   <= '0;
            out_step_reg  <= '0;
            out_fin_reg   <= 1'b0;
        end
        else
        begin
            // In the output state a taken result is replaced there instead.
            if (out_valid_reg && !out_stall && state_reg != ST_OUT)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (restart)
                        begin
                            // Sign-extend or clamp the loaded displacement.
                            disp_reg    <= clamp_s(init_reg);
                            vel_reg     <= '0;
                            elapsed_reg <= '0;
                            count_reg   <= '0;
                            done_reg    <= (tt_c == '0);
                            state_reg   <= ST_OUT;
                        end
                        else if (done_reg || elapsed_reg >= tt_c)
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            scratch_reg[S_W]    <= clamp_u({1'b0, omega_reg});
                            scratch_reg[S_Z]    <= clamp_u({1'b0, zeta_reg});
                            scratch_reg[S_B]    <= clamp_u({7'd0, beta_reg});
                            scratch_reg[S_G]    <= clamp_u({7'd0, gamma_reg});
                            scratch_reg[S_H]    <= h_c;
                            scratch_reg[S_VF]   <= clamp_u({7'd0, vf_reg});
                            scratch_reg[S_D]    <= disp_reg;
                            scratch_reg[S_V]    <= vel_reg;
                            scratch_reg[S_ONE]  <= ONE_C;
                            scratch_reg[S_HALF] <= HALF_C;
                            pc_reg    <= '0;
                            state_reg <= ST_ISSUE;
                        end
                    end
                end
                ST_ISSUE:
                begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (alu_done)
                    begin
                        scratch_reg[uop.dst] <= alu_res;
                        if (pc_reg == 6'(NOPS + 7))
                        begin
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            pc_reg    <= pc_reg + 6'd1;
                            state_reg <= ST_ISSUE;
                        end
                    end
                end
                ST_FINISH:
                begin
                    disp_reg    <= scratch_reg[S_D1];
                    vel_reg     <= scratch_reg[S_V1];
                    elapsed_reg <= tsum_sat;
                    done_reg    <= (tsum_sat >= tt_c);
                    if (count_reg != 32'hffff_ffff)
                    begin
                        count_reg <= count_reg + 32'd1;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        out_disp_reg  <= out_sat(disp_reg);
                        out_vel_reg   <= out_sat(vel_reg);
                        out_step_reg  <= count_reg;
                        out_fin_reg   <= done_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign displacement = out_disp_reg;
    assign velocity     = out_vel_reg;
    assign step_number  = out_step_reg;
    assign finished     = out_fin_reg;

endmodule
